### rtl/core/plrt_pkg.sv
// shared constants and types of the per-level rate thinning core
package plrt_pkg;

	localparam int LEVELS     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int LEVEL_W    = 6;
	localparam int CR_W       = 48;
	localparam int KEY_W      = 64;
	localparam int RATE_W     = 24;
	localparam int HALF_W     = 24;
	localparam int PROD_W     = HALF_W + RATE_W;
	localparam int CFG_W      = 64;
	localparam int CFG_ADDR_W = 3;

	localparam logic [CR_W-1:0] CR_ONE = CR_W'(1) << FRAC_BITS;
	localparam logic [CR_W-1:0] CR_MAX = {1'b0, {(CR_W-1){1'b1}}};
	localparam logic [CR_W-1:0] CR_MIN = {1'b1, {(CR_W-1){1'b0}}};
	localparam logic [CR_W-1:0] IVL_MAX = {CR_W{1'b1}};

	// input commands
	localparam logic CMD_INIT    = 1'b0;
	localparam logic CMD_FEATURE = 1'b1;

	// feature kinds
	localparam logic [1:0] KIND_OTHER   = 2'd0;
	localparam logic [1:0] KIND_POINT   = 2'd1;
	localparam logic [1:0] KIND_LINE    = 2'd2;
	localparam logic [1:0] KIND_POLYGON = 2'd3;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ZOOM     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_ZOOM    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DROP_RATE    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DROP_ENABLE  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_DROP    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_POLYGON_DROP = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_DENSITY_LIM  = 3'd6;

	typedef struct packed {
		logic               clr;
		logic [LVL_W-1:0]   rd_idx;
		logic               cr_we;
		logic               ivl_we;
		logic [LVL_W-1:0]   ivl_idx;
		logic               key_we;
		logic [LEVEL_W-1:0] key_from;
		logic [LVL_W-1:0]   key_to;
	} store_ctl_t;

endpackage

### rtl/core/plrt_rate_mul.sv
// shared 24x24 multiplier with registered product for the interval chain
module plrt_rate_mul (
	input  logic                              clk,
	input  logic [plrt_pkg::HALF_W-1:0]       a,
	input  logic [plrt_pkg::RATE_W-1:0]       b,
	output logic [plrt_pkg::PROD_W-1:0]       prod
);
	import plrt_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

### rtl/core/plrt_level_store.sv
// per-level credit, interval and last kept key registers
module plrt_level_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plrt_pkg::store_ctl_t         ctl,
	input  logic [plrt_pkg::CR_W-1:0]    cr_wdata,
	input  logic [plrt_pkg::CR_W-1:0]    ivl_wdata,
	input  logic [plrt_pkg::KEY_W-1:0]   key_wdata,
	output logic [plrt_pkg::CR_W-1:0]    cr_rd,
	output logic [plrt_pkg::CR_W-1:0]    ivl_rd,
	output logic [plrt_pkg::KEY_W-1:0]   key_rd
);
	import plrt_pkg::*;

	logic [CR_W-1:0]  credit_q [LEVELS];
	logic [CR_W-1:0]  ivl_q    [LEVELS];
	logic [KEY_W-1:0] key_q    [LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LEVELS; j++) credit_q[j] <= '0;
		end else if (ctl.clr) begin
			for (int j = 0; j < LEVELS; j++) credit_q[j] <= '0;
		end else if (ctl.cr_we) begin
			credit_q[ctl.rd_idx] <= cr_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LEVELS; j++) ivl_q[j] <= '0;
		end else if (ctl.clr) begin
			for (int j = 0; j < LEVELS; j++) ivl_q[j] <= '0;
		end else if (ctl.ivl_we) begin
			ivl_q[ctl.ivl_idx] <= ivl_wdata;
		end
	end

	// range write: every level from key_from up to key_to takes the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LEVELS; j++) key_q[j] <= '0;
		end else if (ctl.clr) begin
			for (int j = 0; j < LEVELS; j++) key_q[j] <= '0;
		end else if (ctl.key_we) begin
			for (int j = 0; j < LEVELS; j++) begin
				if (LEVEL_W'(j) >= ctl.key_from && LVL_W'(j) <= ctl.key_to)
					key_q[j] <= key_wdata;
			end
		end
	end

	assign cr_rd  = credit_q[ctl.rd_idx];
	assign ivl_rd = ivl_q[ctl.rd_idx];
	assign key_rd = key_q[ctl.rd_idx];

endmodule

### rtl/core/per_level_rate_thinning_core.sv
// top level: configuration, sequencer and result register of the thinning core
//
// Input channel (in_valid/in_ready) takes one word: cmd, kind, index_key.
// cmd init clears every level and rebuilds the level intervals; it gives no
// result. cmd feature gives one min_level word on the output channel
// (out_valid/out_ready).
// in_ready is high only while the sequencer is idle; one word is worked on
// at a time.
// Feature that is not thinned: the sequencer goes from idle straight to the
// done state, which loads the output register once the slot is free.
// Thinned feature: the walk visits one level a cycle from the top level down,
// then the density check one level a cycle upwards, then the done state.
// Init: after the clear, the interval chain runs base_zoom steps; each step
// passes through the low half, high half and combine states on the shared
// 24x24 multiplier.
// Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user must
// do so only while idle, as the core itself does not enforce it.
// Reset loads the register defaults and clears all level state.
// The result sits in an output register; while the receiver stalls the core
// can take and work on the next word, holding its result until the slot
// frees.
module per_level_rate_thinning_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [1:0]                         kind,
	input  logic [plrt_pkg::KEY_W-1:0]         index_key,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [plrt_pkg::LEVEL_W-1:0]       min_level,
	input  logic                               cfg_wen,
	input  logic [plrt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [plrt_pkg::CFG_W-1:0]         cfg_wdata
);
	import plrt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_INIT  = 8'b0000_0010,
		S_MUL_L = 8'b0000_0100,
		S_MUL_H = 8'b0000_1000,
		S_COMB  = 8'b0001_0000,
		S_WALK  = 8'b0010_0000,
		S_DENS  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	localparam int SUM_W = PROD_W + HALF_W - FRAC_BITS + 1;
	localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (FRAC_BITS - 1);

	// configuration
	logic [4:0]        max_zoom_q;
	logic [5:0]        base_zoom_q;
	logic [RATE_W-1:0] drop_rate_q;
	logic              drop_en_q;
	logic              line_drop_q;
	logic              poly_drop_q;
	logic [KEY_W-1:0]  dens_lim_q;

	// sequencer
	state_t             state_q;
	logic [LVL_W-1:0]   idx_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic               found_q;
	logic [5:0]         lv_q;
	logic               out_valid_q;

	// working data
	logic [KEY_W-1:0]         key_q;
	logic [KEY_W-1:0]         lim_q;
	logic [CR_W-1:0]          p_q;
	logic [PROD_W-FRAC_BITS:0] acc_q;
	logic [LEVEL_W-1:0]       min_level_q;

	store_ctl_t        ctl;
	logic [CR_W-1:0]   cr_rd, ivl_rd, cr_wdata;
	logic [KEY_W-1:0]  key_rd;
	logic [HALF_W-1:0] mul_a;
	logic [PROD_W-1:0] prod;

	logic [LVL_W-1:0] top_lvl;
	logic             thin;
	logic             slot_free;
	logic [CR_W:0]    inc_sum;
	logic [CR_W-1:0]  c1;
	logic [CR_W+1:0]  dec_sum;
	logic [CR_W-1:0]  c2;
	logic             c1_neg;
	logic [PROD_W:0]  rnd_sum;
	logic [SUM_W-1:0] comb_sum;
	logic [CR_W-1:0]  p_next;
	logic [5:0]       lv_m1;
	logic [KEY_W-1:0] gap;
	logic             dens_go;
	logic             dens_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_zoom_q  <= 5'd14;
			base_zoom_q <= 6'd14;
			drop_rate_q <= 24'd163840;
			drop_en_q   <= 1'b1;
			line_drop_q <= 1'b0;
			poly_drop_q <= 1'b0;
			dens_lim_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_MAX_ZOOM:     max_zoom_q  <= cfg_wdata[4:0];
				REG_BASE_ZOOM:    base_zoom_q <= cfg_wdata[5:0];
				REG_DROP_RATE:    drop_rate_q <= cfg_wdata[RATE_W-1:0];
				REG_DROP_ENABLE:  drop_en_q   <= cfg_wdata[0];
				REG_LINE_DROP:    line_drop_q <= cfg_wdata[0];
				REG_POLYGON_DROP: poly_drop_q <= cfg_wdata[0];
				REG_DENSITY_LIM:  dens_lim_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (LEVEL_W'(max_zoom_q) < LEVEL_W'(LEVELS)) top_lvl = LVL_W'(max_zoom_q);
		else top_lvl = LVL_W'(LEVELS - 1);
	end

	assign thin = drop_en_q && (kind == KIND_POINT || (kind == KIND_LINE && line_drop_q) ||
		(kind == KIND_POLYGON && poly_drop_q));

	assign slot_free = !out_valid_q || out_ready;

	// credit: add a unit, pay interval unless found or c1 < 0; saturating
	assign inc_sum = {cr_rd[CR_W-1], cr_rd} + {1'b0, CR_ONE};
	assign c1      = (inc_sum[CR_W] != inc_sum[CR_W-1]) ? CR_MAX : inc_sum[CR_W-1:0];
	assign c1_neg  = c1[CR_W-1];
	assign dec_sum = {c1[CR_W-1], c1[CR_W-1], c1} - {2'b00, ivl_rd};
	assign c2      = (dec_sum[CR_W+1] != dec_sum[CR_W-1] || dec_sum[CR_W] != dec_sum[CR_W-1]) ?
		CR_MIN : dec_sum[CR_W-1:0];
	assign cr_wdata = (found_q || c1_neg) ? c1 : c2;

	// interval chain: p * rate / 2^FRAC_BITS, rounded half up, saturated
	assign mul_a    = (state_q == S_MUL_H) ? p_q[2*HALF_W-1:HALF_W] : p_q[HALF_W-1:0];
	assign rnd_sum  = {1'b0, prod} + RND;
	assign comb_sum = (SUM_W'(prod) << (HALF_W - FRAC_BITS)) + SUM_W'(acc_q);
	assign p_next   = (comb_sum > SUM_W'(IVL_MAX)) ? IVL_MAX : comb_sum[CR_W-1:0];
	assign lv_m1    = lv_q - 6'd1;

	// density rule
	assign gap      = key_q - key_rd;
	assign dens_go  = (dens_lim_q != '0) && (LEVEL_W'(idx_q) < lvl_q) && (idx_q < top_lvl);
	assign dens_hit = gap > lim_q;

	always_comb begin
		ctl          = '0;
		ctl.clr      = (state_q == S_INIT);
		ctl.rd_idx   = idx_q;
		ctl.cr_we    = (state_q == S_WALK);
		ctl.ivl_we   = (state_q == S_COMB) && (lv_m1 < LEVEL_W'(LEVELS));
		ctl.ivl_idx  = LVL_W'(lv_m1);
		ctl.key_we   = (state_q == S_DONE) && slot_free && found_q;
		ctl.key_from = lvl_q;
		ctl.key_to   = top_lvl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			lvl_q       <= '0;
			found_q     <= 1'b0;
			lv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
						lvl_q   <= '0;
						idx_q   <= top_lvl;
						if (cmd == CMD_INIT) state_q <= S_INIT;
						else if (thin) state_q <= S_WALK;
						else state_q <= S_DONE;
					end
				end
				S_INIT: begin
					lv_q <= base_zoom_q;
					state_q <= (base_zoom_q == '0) ? S_IDLE : S_MUL_L;
				end
				S_MUL_L: state_q <= S_MUL_H;
				S_MUL_H: state_q <= S_COMB;
				S_COMB: begin
					lv_q <= lv_m1;
					state_q <= (lv_m1 == '0) ? S_IDLE : S_MUL_L;
				end
				S_WALK: begin
					if (!found_q && c1_neg) begin
						found_q <= 1'b1;
						lvl_q   <= LEVEL_W'(idx_q) + LEVEL_W'(1);
					end
					if (idx_q == '0) state_q <= S_DENS;
					else idx_q <= idx_q - LVL_W'(1);
				end
				S_DENS: begin
					if (!dens_go) begin
						state_q <= S_DONE;
					end else if (dens_hit) begin
						found_q <= 1'b1;
						lvl_q   <= LEVEL_W'(idx_q);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + LVL_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) key_q <= index_key;
		if (state_q == S_INIT) p_q <= CR_ONE;
		if (state_q == S_COMB) p_q <= p_next;
		if (state_q == S_MUL_H) acc_q <= rnd_sum[PROD_W:FRAC_BITS];
		if (state_q == S_WALK) lim_q <= dens_lim_q;
		if (state_q == S_DENS) lim_q <= lim_q >> 2;
		if (state_q == S_DONE && slot_free) min_level_q <= lvl_q;
	end

	plrt_level_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cr_wdata  (cr_wdata),
		.ivl_wdata (p_next),
		.key_wdata (key_q),
		.cr_rd     (cr_rd),
		.ivl_rd    (ivl_rd),
		.key_rd    (key_rd)
	);

	plrt_rate_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (drop_rate_q),
		.prod (prod)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign min_level = min_level_q;

	// a result never names a level above the level count LEVELS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_level <= LEVEL_W'(LEVELS))
		else $error("min_level out of range");

	// the walk stays inside the levels in use
	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_DENS) |-> idx_q <= top_lvl)
		else $error("level index beyond top level");

	// the interval chain never runs with its step count exhausted
	a_chain_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_L || state_q == S_MUL_H || state_q == S_COMB) |-> lv_q != '0)
		else $error("interval chain step count underflow");

	// an accepted word always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE)
		else $error("accepted word did not start the sequencer");

endmodule
